[hw/rtl/stl_pkg.sv]
// shared constants, codes and types for the sorted two-key table lookup
package stl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int Z_W     = 8;
    localparam int N_W     = 9;
    localparam int E_W     = 40;
    localparam int X_W     = 48;
    localparam int CFG_W   = 32;
    localparam int MA_W    = 10;
    localparam int PROD_W  = MA_W + CFG_W;
    localparam int ACC_W   = 50;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam logic [1:0] REG_AMU = 2'd0;
    localparam logic [1:0] REG_PEM = 2'd1;
    localparam logic [1:0] REG_NM  = 2'd2;

    localparam logic [CFG_W-1:0] AMU_RESET = 32'd61046182;
    localparam logic [CFG_W-1:0] PEM_RESET = 32'd61523280;
    localparam logic [CFG_W-1:0] NM_RESET  = 32'd61607961;

    typedef struct packed {
        logic [1:0]     op;
        logic [Z_W-1:0] z;
        logic [N_W-1:0] nq;
        logic [E_W-1:0] energy;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] amu;
        logic [CFG_W-1:0] pem;
        logic [CFG_W-1:0] nm;
    } t_cfg;

endpackage

[hw/rtl/stl_front.sv]
// input stage: takes words and classifies them into commands
module stl_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_mode,
    input  logic [stl_pkg::Z_W-1:0]  i_protons,
    input  logic [stl_pkg::N_W-1:0]  i_neutrons,
    input  logic [stl_pkg::E_W-1:0]  i_energy,
    output logic                     o_push,
    input  logic                     i_push_ready,
    output stl_pkg::t_cmd            o_cmd
);

    logic          r_valid;
    logic          n_valid;
    stl_pkg::t_cmd r_cmd;
    stl_pkg::t_cmd w_cmd;
    logic          w_take;

    assign o_in_stall = r_valid && !i_push_ready;
    assign w_take     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        w_cmd.z      = i_protons;
        w_cmd.nq     = i_neutrons;
        w_cmd.energy = i_energy;
        unique case (i_mode)
            stl_pkg::MODE_APPEND: begin
                w_cmd.op = stl_pkg::CMD_APPEND;
            end
            stl_pkg::MODE_LOOKUP: begin
                w_cmd.op = stl_pkg::CMD_LOOKUP;
            end
            stl_pkg::MODE_CLEAR: begin
                w_cmd.op = stl_pkg::CMD_CLEAR;
                w_cmd.energy = '0;
            end
            default: begin
                w_cmd.op = stl_pkg::CMD_NOP;
                w_cmd.energy = '0;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

[hw/rtl/stl_queue.sv]
// short command queue between the front and back parts
module stl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stl_pkg::t_cmd i_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output stl_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    stl_pkg::t_cmd                r_slot [stl_pkg::QUEUE_DEPTH];
    logic [stl_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [stl_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [stl_pkg::QCNT_W-1:0]   r_count;
    logic [stl_pkg::QPTR_W-1:0]   n_wr_ptr;
    logic [stl_pkg::QPTR_W-1:0]   n_rd_ptr;
    logic [stl_pkg::QCNT_W-1:0]   n_count;
    logic                         w_do_push;
    logic                         w_do_pop;

    assign o_push_ready = r_count != stl_pkg::QCNT_W'(stl_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_cmd        = r_slot[r_rd_ptr];
    assign w_do_push    = i_push && o_push_ready;
    assign w_do_pop     = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == stl_pkg::QPTR_W'(stl_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == stl_pkg::QPTR_W'(stl_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/stl_back.sv]
// back part: entry table, search sequencer, mass excess arithmetic, result register
module stl_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  stl_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    input  stl_pkg::t_cfg                   i_cfg,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic                            o_found,
    output logic signed [stl_pkg::X_W-1:0]  o_mass_excess
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MID  = 3'd1;
    localparam logic [2:0] S_BIN  = 3'd2;
    localparam logic [2:0] S_LO   = 3'd3;
    localparam logic [2:0] S_HI   = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_CALC = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    localparam int AW = stl_pkg::ADDR_W;
    localparam int CW = stl_pkg::CNT_W;

    typedef struct packed {
        logic [stl_pkg::Z_W-1:0] z;
        logic [stl_pkg::N_W-1:0] nq;
        logic [stl_pkg::E_W-1:0] energy;
    } t_entry;

    t_entry mem [stl_pkg::TABLE_DEPTH];
    t_entry r_rd_q;
    t_entry w_wr_data;
    logic   w_wr_en;

    logic [2:0]                         r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [AW-1:0]                      r_addr, n_addr;
    logic [AW-1:0]                      r_lo, n_lo;
    logic [AW-1:0]                      r_hi, n_hi;
    logic                               r_dir_up, n_dir_up;
    logic                               r_dir_dn, n_dir_dn;
    logic [stl_pkg::Z_W-1:0]            r_z, n_z;
    logic [stl_pkg::N_W-1:0]            r_nq, n_nq;
    logic [1:0]                         r_step, n_step;
    logic [stl_pkg::PROD_W-1:0]         r_prod, n_prod;
    logic                               r_neg, n_neg;
    logic signed [stl_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [1:0]                         r_res_status, n_res_status;
    logic                               r_res_found, n_res_found;
    logic                               r_out_valid, n_out_valid;
    logic [1:0]                         r_out_status, n_out_status;
    logic                               r_out_found, n_out_found;
    logic signed [stl_pkg::X_W-1:0]     r_out_excess, n_out_excess;

    logic [AW-1:0]                      w_last;
    logic [AW-1:0]                      w_lo, w_hi;
    logic [AW:0]                        w_sum;
    logic                               w_more;
    logic                               w_full;
    logic [stl_pkg::MA_W-1:0]           w_mul_a;
    logic [stl_pkg::CFG_W-1:0]          w_mul_b;
    logic [stl_pkg::PROD_W-1:0]         w_product;
    logic signed [stl_pkg::ACC_W-1:0]   w_prod_s;
    logic                               w_ovf;
    logic signed [stl_pkg::X_W-1:0]     w_sat;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_mass_excess = r_out_excess;

    assign w_last    = AW'(r_count - 1'b1);
    assign w_full    = r_count == CW'(stl_pkg::TABLE_DEPTH);
    assign w_wr_data = '{z: i_cmd.z, nq: i_cmd.nq, energy: i_cmd.energy};

    // bracket update from the entry just read
    always_comb begin
        w_lo = r_lo;
        w_hi = r_hi;
        case (r_state)
            S_MID: begin
                if (r_rd_q.z > r_z) begin
                    w_lo = '0;
                    w_hi = r_addr;
                end else begin
                    w_lo = r_addr;
                    w_hi = w_last;
                end
            end
            S_BIN: begin
                if (r_rd_q.z < r_z) begin
                    w_lo = r_addr;
                end else begin
                    w_hi = r_addr;
                end
            end
            default: begin
                w_lo = r_lo;
                w_hi = r_hi;
            end
        endcase
    end

    assign w_sum  = {1'b0, w_lo} + {1'b0, w_hi};
    assign w_more = {1'b0, w_hi} > ({1'b0, w_lo} + (AW + 1)'(1));

    // one shared multiplier, three products in turn
    always_comb begin
        case (r_step)
            2'd0: begin
                w_mul_a = {2'b00, r_z} + {1'b0, r_nq};
                w_mul_b = i_cfg.amu;
            end
            2'd1: begin
                w_mul_a = stl_pkg::MA_W'(r_z);
                w_mul_b = i_cfg.pem;
            end
            2'd2: begin
                w_mul_a = stl_pkg::MA_W'(r_nq);
                w_mul_b = i_cfg.nm;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_product = w_mul_a * w_mul_b;
    assign w_prod_s  = $signed({{(stl_pkg::ACC_W - stl_pkg::PROD_W){1'b0}}, r_prod});

    assign w_ovf = !((&r_acc[stl_pkg::ACC_W-1:stl_pkg::X_W-1])
                     || !(|r_acc[stl_pkg::ACC_W-1:stl_pkg::X_W-1]));
    assign w_sat = w_ovf ? (r_acc[stl_pkg::ACC_W-1] ? {1'b1, {(stl_pkg::X_W-1){1'b0}}}
                                                     : {1'b0, {(stl_pkg::X_W-1){1'b1}}})
                         : r_acc[stl_pkg::X_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_dir_up     = r_dir_up;
        n_dir_dn     = r_dir_dn;
        n_z          = r_z;
        n_nq         = r_nq;
        n_step       = r_step;
        n_prod       = r_prod;
        n_neg        = r_neg;
        n_acc        = r_acc;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_excess = r_out_excess;
        o_cmd_pop    = 1'b0;
        w_wr_en      = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_res_status = stl_pkg::STATUS_OK;
                    n_res_found  = 1'b0;
                    n_z          = i_cmd.z;
                    n_nq         = i_cmd.nq;
                    n_dir_up     = 1'b0;
                    n_dir_dn     = 1'b0;
                    n_state      = S_EMIT;
                    unique case (i_cmd.op)
                        stl_pkg::CMD_APPEND: begin
                            if (w_full) begin
                                n_res_status = stl_pkg::STATUS_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        stl_pkg::CMD_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res_status = stl_pkg::STATUS_NOT_FOUND;
                            end else begin
                                n_addr  = AW'(r_count >> 1);
                                n_state = S_MID;
                            end
                        end
                        stl_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_res_status = stl_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_MID, S_BIN: begin
                if (r_state == S_MID && r_rd_q.z == r_z) begin
                    n_state = S_WALK;
                end else begin
                    n_lo = w_lo;
                    n_hi = w_hi;
                    if (w_more) begin
                        n_addr  = w_sum[AW:1];
                        n_state = S_BIN;
                    end else begin
                        n_addr  = w_lo;
                        n_state = S_LO;
                    end
                end
            end
            S_LO: begin
                if (r_rd_q.z == r_z) begin
                    n_state = S_WALK;
                end else begin
                    n_addr  = r_hi;
                    n_state = S_HI;
                end
            end
            S_HI: begin
                if (r_rd_q.z == r_z) begin
                    n_state = S_WALK;
                end else begin
                    n_res_status = stl_pkg::STATUS_NOT_FOUND;
                    n_state      = S_EMIT;
                end
            end
            S_WALK: begin
                if (r_rd_q.z != r_z) begin
                    n_res_status = stl_pkg::STATUS_NOT_FOUND;
                    n_state      = S_EMIT;
                end else if (r_rd_q.nq == r_nq) begin
                    n_res_found = 1'b1;
                    n_acc       = $signed({{(stl_pkg::ACC_W - stl_pkg::E_W)
                                            {r_rd_q.energy[stl_pkg::E_W-1]}},
                                           r_rd_q.energy});
                    n_step      = 2'd0;
                    n_state     = S_CALC;
                end else if (r_rd_q.nq > r_nq) begin
                    if (r_dir_up || r_addr == '0) begin
                        n_res_status = stl_pkg::STATUS_NOT_FOUND;
                        n_state      = S_EMIT;
                    end else begin
                        n_dir_dn = 1'b1;
                        n_addr   = r_addr - 1'b1;
                    end
                end else begin
                    if (r_dir_dn || r_addr >= w_last) begin
                        n_res_status = stl_pkg::STATUS_NOT_FOUND;
                        n_state      = S_EMIT;
                    end else begin
                        n_dir_up = 1'b1;
                        n_addr   = r_addr + 1'b1;
                    end
                end
            end
            S_CALC: begin
                n_prod = w_product;
                n_neg  = r_step == 2'd0;
                n_step = r_step + 1'b1;
                if (r_step != 2'd0) begin
                    n_acc = r_neg ? r_acc - w_prod_s : r_acc + w_prod_s;
                end
                if (r_step == 2'd3) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_out_excess = r_res_found ? w_sat : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count[AW-1:0]] <= w_wr_data;
        end
        r_rd_q <= mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_dir_up     <= n_dir_up;
        r_dir_dn     <= n_dir_dn;
        r_z          <= n_z;
        r_nq         <= n_nq;
        r_step       <= n_step;
        r_prod       <= n_prod;
        r_neg        <= n_neg;
        r_acc        <= n_acc;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_excess <= n_out_excess;
    end

endmodule

[hw/rtl/sorted_two_key_table_lookup.sv]
// top level: register port, input stage, command queue and search back end
//
// Keeps a table of up to 1024 entries (protons, neutrons, energy), which the
// user must append sorted by protons then neutrons; the block does not enforce
// it. Input words carry a mode: append adds an entry at the end, clear empties
// the table, lookup finds an entry and returns its mass excess. Every word
// gives exactly one result word, in order. Input and output channels use
// valid/stall; a word moves at a clock edge with valid high and stall low. The
// input stage and a two-deep queue keep taking words while a result waits at
// a stalled output. A lookup is set by the single read port of the entry
// memory: one probe per cycle, one at the midpoint, up to about log2(entries)
// binary steps, one or two end checks and one per entry of the neutron walk,
// then S_CALC on the shared multiplier and S_EMIT to the output register. One
// word is worked on at a time in the back end. Reset empties the table and
// loads the three mass constants with their defaults; entry memory contents
// are not cleared. Constants are written over the APB port at byte addresses
// 0, 4 and 8; the user must do so only while the block is idle, which the
// block itself does not enforce.
module sorted_two_key_table_lookup (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_mode,
    input  logic [stl_pkg::Z_W-1:0]         i_protons,
    input  logic [stl_pkg::N_W-1:0]         i_neutrons,
    input  logic signed [stl_pkg::E_W-1:0]  i_energy,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic                            o_found,
    output logic signed [stl_pkg::X_W-1:0]  o_mass_excess,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [stl_pkg::APB_AW-1:0]      paddr,
    input  logic [stl_pkg::APB_DW-1:0]      pwdata,
    output logic [stl_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);

    stl_pkg::t_cfg r_cfg;
    stl_pkg::t_cfg n_cfg;
    stl_pkg::t_cmd w_front_cmd;
    stl_pkg::t_cmd w_queue_cmd;
    logic          w_push;
    logic          w_push_ready;
    logic          w_pop_valid;
    logic          w_pop;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_cfg_wr) begin
            unique case (paddr[3:2])
                stl_pkg::REG_AMU: n_cfg.amu = pwdata;
                stl_pkg::REG_PEM: n_cfg.pem = pwdata;
                stl_pkg::REG_NM:  n_cfg.nm  = pwdata;
                default:          n_cfg     = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            stl_pkg::REG_AMU: prdata = r_cfg.amu;
            stl_pkg::REG_PEM: prdata = r_cfg.pem;
            stl_pkg::REG_NM:  prdata = r_cfg.nm;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amu <= stl_pkg::AMU_RESET;
            r_cfg.pem <= stl_pkg::PEM_RESET;
            r_cfg.nm  <= stl_pkg::NM_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    stl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_protons    (i_protons),
        .i_neutrons   (i_neutrons),
        .i_energy     (i_energy),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_front_cmd)
    );

    stl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_front_cmd),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_cmd        (w_queue_cmd),
        .i_pop        (w_pop)
    );

    stl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_pop_valid),
        .i_cmd         (w_queue_cmd),
        .o_cmd_pop     (w_pop),
        .i_cfg         (r_cfg),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_mass_excess (o_mass_excess)
    );

endmodule

[hw/rtl/stl_checker.sv]
// port-level checks for the sorted two-key table lookup, bound to the top level
module stl_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [1:0]                      o_status,
    input logic                            o_found,
    input logic signed [stl_pkg::X_W-1:0]  o_mass_excess
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == stl_pkg::STATUS_OK)
        else $error("found result with non-ok status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_mass_excess == '0)
        else $error("mass excess not zero without a match");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result word shown straight after reset");

endmodule

bind sorted_two_key_table_lookup stl_checker u_stl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_found       (o_found),
    .o_mass_excess (o_mass_excess)
);
